FILE: sv/circq_pkg.sv
// ----------------------------------------------------------------------------
// circq_pkg
// Shared codes of the circular queue: operations and result status.
// ----------------------------------------------------------------------------
package circq_pkg;

  typedef enum logic [1:0] {
    OP_PUSH   = 2'd0,
    OP_POP    = 2'd1,
    OP_SEARCH = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_e;

  localparam int unsigned ValueW = 32;
  localparam int unsigned SlotW  = 4;

endpackage

FILE: sv/circq_ram.sv
// ----------------------------------------------------------------------------
// circq_ram
// Generic single-write, single-read synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module circq_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: sv/circular_queue_with_search.sv
// ----------------------------------------------------------------------------
// circular_queue_with_search
// Ring-buffer FIFO of signed 32-bit words with push, pop and a linear search
// from head to tail that returns the slot of the first matching entry.
// ----------------------------------------------------------------------------
//   channel | direction | handshake             | fields
//   in      | input     | in_valid_i/in_stall_o | opcode, value
//   out     | output    | out_valid_o/out_stall_i | status, popped_value, found_slot
//
// Push, empty pop/search and unknown opcodes load the result when accepted.
// Pop: one RAM read, result loaded in S_POP. Search: one stored entry read and
// compared per cycle through the single RAM read port; it stops at the first match.
// Reset clears head, tail and occupancy; slot contents are left as they are.
// A stalled result sits in the output register; the next item is taken in
// the cycle that result leaves.
// ----------------------------------------------------------------------------
module circular_queue_with_search #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [1:0]                        in_opcode_i,
  input  logic signed [circq_pkg::ValueW-1:0] in_value_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output circq_pkg::status_e                out_status_o,
  output logic signed [circq_pkg::ValueW-1:0] out_popped_value_o,
  output logic [circq_pkg::SlotW-1:0]       out_found_slot_o
);
  import circq_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned OW = $clog2(DEPTH + 1);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_POP  = 3'b010,
    S_SRCH = 3'b100
  } state_e;

  state_e            state_q, state_d;
  logic [AW-1:0]     head_q, head_d;
  logic [AW-1:0]     tail_q, tail_d;
  logic [OW-1:0]     occ_q, occ_d;
  logic [AW-1:0]     iss_idx_q, iss_idx_d;
  logic [AW-1:0]     cmp_idx_q, cmp_idx_d;
  logic [OW-1:0]     iss_cnt_q, iss_cnt_d;
  logic [ValueW-1:0] key_q, key_d;

  logic              out_valid_q, out_valid_d;
  status_e           status_q, status_d;
  logic [ValueW-1:0] popped_q, popped_d;
  logic [SlotW-1:0]  found_q, found_d;
  logic              out_load;

  logic              accept;
  logic              ram_we, ram_re;
  logic [AW-1:0]     ram_raddr;
  logic [ValueW-1:0] ram_rdata;
  logic [AW+SlotW-1:0] cmp_idx_ext;

  function automatic logic [AW-1:0] next_idx(logic [AW-1:0] idx);
    logic [AW-1:0] r;
    if (idx == AW'(DEPTH - 1)) begin
      r = '0;
    end else begin
      r = idx + 1'b1;
    end
    return r;
  endfunction

  assign in_stall_o = (state_q != S_IDLE) || (out_valid_q && out_stall_i);
  assign accept     = in_valid_i && !in_stall_o;
  assign cmp_idx_ext = {{SlotW{1'b0}}, cmp_idx_q};

  always_comb begin
    state_d   = state_q;
    head_d    = head_q;
    tail_d    = tail_q;
    occ_d     = occ_q;
    iss_idx_d = iss_idx_q;
    cmp_idx_d = cmp_idx_q;
    iss_cnt_d = iss_cnt_q;
    key_d     = key_q;
    out_load  = 1'b0;
    status_d  = ST_OK;
    popped_d  = '0;
    found_d   = '0;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_raddr = head_q;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (in_opcode_i)
            OP_PUSH: begin
              out_load = 1'b1;
              if (occ_q == OW'(DEPTH)) begin
                status_d = ST_FULL;
              end else begin
                ram_we = 1'b1;
                tail_d = next_idx(tail_q);
                occ_d  = occ_q + 1'b1;
              end
            end
            OP_POP: begin
              if (occ_q == '0) begin
                out_load = 1'b1;
                status_d = ST_EMPTY;
              end else begin
                ram_re  = 1'b1;
                state_d = S_POP;
              end
            end
            OP_SEARCH: begin
              if (occ_q == '0) begin
                out_load = 1'b1;
                status_d = ST_EMPTY;
              end else begin
                ram_re    = 1'b1;
                key_d     = in_value_i;
                cmp_idx_d = head_q;
                iss_idx_d = next_idx(head_q);
                iss_cnt_d = OW'(1);
                state_d   = S_SRCH;
              end
            end
            default: begin
              out_load = 1'b1;
            end
          endcase
        end
      end
      S_POP: begin
        out_load = 1'b1;
        popped_d = ram_rdata;
        head_d   = next_idx(head_q);
        occ_d    = occ_q - 1'b1;
        state_d  = S_IDLE;
      end
      S_SRCH: begin
        ram_raddr = iss_idx_q;
        if (ram_rdata == key_q) begin
          out_load = 1'b1;
          found_d  = cmp_idx_ext[SlotW-1:0];
          state_d  = S_IDLE;
        end else if (iss_cnt_q == occ_q) begin
          out_load = 1'b1;
          status_d = ST_NOT_FOUND;
          state_d  = S_IDLE;
        end else begin
          ram_re    = 1'b1;
          cmp_idx_d = iss_idx_q;
          iss_idx_d = next_idx(iss_idx_q);
          iss_cnt_d = iss_cnt_q + 1'b1;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign out_valid_d = out_load || (out_valid_q && out_stall_i);

  circq_ram #(
    .Width(ValueW),
    .Depth(DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(tail_q),
    .wdata_i(in_value_i),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      head_q      <= '0;
      tail_q      <= '0;
      occ_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      occ_q       <= occ_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    iss_idx_q <= iss_idx_d;
    cmp_idx_q <= cmp_idx_d;
    iss_cnt_q <= iss_cnt_d;
    key_q     <= key_d;
    if (out_load) begin
      status_q <= status_d;
      popped_q <= popped_d;
      found_q  <= found_d;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign out_status_o       = status_q;
  assign out_popped_value_o = popped_q;
  assign out_found_slot_o   = found_q;

  a_occ_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= OW'(DEPTH))
    else $error("occupancy above depth");

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> !(out_valid_q && out_stall_i))
    else $error("result loaded over a pending result");

  a_srch_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SRCH) |-> (iss_cnt_q != '0) && (iss_cnt_q <= occ_q))
    else $error("search read count out of range");

  a_push_occ: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |=> (occ_q == $past(occ_q) + 1'b1))
    else $error("push did not grow occupancy");

endmodule
